### rtl/assert_macros.svh
// Assertion macros shared by the timer scheduler RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("timer scheduler check failed");
// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("timer scheduler check failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### rtl/tes_pkg.sv
// Shared types and codes for the timer event scheduler.
// No dependencies; imported by tes_cell, timer_event_scheduler and the testbench.
package tes_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_IDLE  = 2'd2,
    KIND_FIRED = 2'd3
  } result_kind_t;

  // Command broadcast to every cell of the queue.
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_cmd_t;

endpackage

### rtl/timer_event_scheduler.sv
// Earliest-deadline timer queue built as a row of tes_cell slots.
// Depends on tes_pkg, tes_cell and assert_macros.svh.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_stall  | operation, event_tag, repeating, interval
//   out     | out_valid, out_stall| result_kind, fired_tag, pending_count
//
// An add passes ST_INSERT, or goes straight to ST_DONE on a full queue; a tick
// passes ST_CHECK, and ST_INSERT too when a repeating event fires. The queue
// row does one broadcast compare per insert, and pop and re-insert of a
// repeating event run in separate cycles. One item is in flight at a time;
// the next one is accepted as soon as the result sits in the output register.
// Reset clears time, occupancy and the control; slot contents need no reset.
`include "assert_macros.svh"

module timer_event_scheduler import tes_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [15:0] event_tag,
  input  logic        repeating,
  input  logic [31:0] interval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [15:0] fired_tag,
  output logic [6:0]  pending_count
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INSERT,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [TIME_BITS-1:0]   current_time;
  logic [TIME_BITS-1:0]   key_deadline;
  logic [31:0]            key_period;
  logic [15:0]            key_label;
  logic                   key_repeats;
  result_kind_t           res_kind;
  logic [15:0]            res_tag;

  logic [TIME_BITS-1:0]   cell_deadline [QUEUE_DEPTH];
  logic [31:0]            cell_period   [QUEUE_DEPTH];
  logic [15:0]            cell_label    [QUEUE_DEPTH];
  logic                   cell_repeats  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_gt;

  cell_cmd_t              cmd;
  logic                   accept;
  logic                   fire;
  logic [31:0]            sum_period;
  logic [TIME_BITS:0]     sum_ext;
  logic [TIME_BITS-1:0]   key_sum;
  logic [TIME_BITS-1:0]   time_inc;
  logic [CW+6:0]          count_ext;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Saturating deadline: now plus the add's interval, or plus the head's period.
  assign sum_period = (state == ST_IDLE) ? interval : cell_period[0];
  assign sum_ext    = {1'b0, current_time} + {(TIME_BITS + 1 - 32)'(0), sum_period};
  assign key_sum    = sum_ext[TIME_BITS] ? TIME_MAX : sum_ext[TIME_BITS-1:0];
  assign time_inc   = (current_time == TIME_MAX) ? current_time : current_time + 1'b1;

  assign fire       = (count != '0) && (cell_deadline[0] <= current_time);
  assign cmd.pop    = (state == ST_CHECK) && fire;
  assign cmd.insert = (state == ST_INSERT);
  assign count_ext  = {7'd0, count};

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 p_gt;
      logic [TIME_BITS-1:0] p_deadline;
      logic [31:0]          p_period;
      logic [15:0]          p_label;
      logic                 p_repeats;
      logic [TIME_BITS-1:0] n_deadline;
      logic [31:0]          n_period;
      logic [15:0]          n_label;
      logic                 n_repeats;

      if (i == 0) begin : g_head
        assign p_gt       = 1'b0;
        assign p_deadline = key_deadline;
        assign p_period   = key_period;
        assign p_label    = key_label;
        assign p_repeats  = key_repeats;
      end else begin : g_body
        assign p_gt       = cell_gt[i-1];
        assign p_deadline = cell_deadline[i-1];
        assign p_period   = cell_period[i-1];
        assign p_label    = cell_label[i-1];
        assign p_repeats  = cell_repeats[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign n_deadline = cell_deadline[i];
        assign n_period   = cell_period[i];
        assign n_label    = cell_label[i];
        assign n_repeats  = cell_repeats[i];
      end else begin : g_inner
        assign n_deadline = cell_deadline[i+1];
        assign n_period   = cell_period[i+1];
        assign n_label    = cell_label[i+1];
        assign n_repeats  = cell_repeats[i+1];
      end

      tes_cell #(
        .TIME_BITS   (TIME_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .INDEX       (i)
      ) u_cell (
        .clk           (clk),
        .cmd           (cmd),
        .count         (count),
        .key_deadline  (key_deadline),
        .key_period    (key_period),
        .key_label     (key_label),
        .key_repeats   (key_repeats),
        .prev_gt       (p_gt),
        .prev_deadline (p_deadline),
        .prev_period   (p_period),
        .prev_label    (p_label),
        .prev_repeats  (p_repeats),
        .next_deadline (n_deadline),
        .next_period   (n_period),
        .next_label    (n_label),
        .next_repeats  (n_repeats),
        .gt            (cell_gt[i]),
        .deadline      (cell_deadline[i]),
        .period        (cell_period[i]),
        .label         (cell_label[i]),
        .repeats       (cell_repeats[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      current_time <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Drop a taken result; ST_DONE loads the next one itself.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation == OP_ADD) begin
              res_tag <= '0;
              if (count == FULL_COUNT) begin
                res_kind <= KIND_FULL;
                state    <= ST_DONE;
              end else begin
                key_deadline <= key_sum;
                key_period   <= interval;
                key_label    <= event_tag;
                key_repeats  <= repeating;
                res_kind     <= KIND_ADDED;
                state        <= ST_INSERT;
              end
            end else begin
              current_time <= time_inc;
              state        <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (fire) begin
            res_kind <= KIND_FIRED;
            res_tag  <= cell_label[0];
            count    <= count - 1'b1;
            if (cell_repeats[0]) begin
              // Put the head back at its next due time.
              key_deadline <= key_sum;
              key_period   <= cell_period[0];
              key_label    <= cell_label[0];
              key_repeats  <= 1'b1;
              state        <= ST_INSERT;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            res_kind <= KIND_IDLE;
            res_tag  <= '0;
            state    <= ST_DONE;
          end
        end
        ST_INSERT: begin
          count <= count + 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            result_kind   <= res_kind;
            fired_tag     <= res_tag;
            pending_count <= count_ext[6:0];
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_reset_idle, rst |=> ((state == ST_IDLE) && !out_valid))
  `ASSERT_CLK(a_count_bound, count <= FULL_COUNT)
  `ASSERT_CLK(a_insert_room, (state == ST_INSERT) |-> (count < FULL_COUNT))
  `ASSERT_CLK(a_time_monotonic, ##1 (current_time >= $past(current_time)))
  `ASSERT_CLK(a_head_order, (count >= CW'(2)) |-> (cell_deadline[0] <= cell_deadline[1]))
  `ASSERT_CLK(a_tag_only_on_fire,
              (out_valid && (result_kind != KIND_FIRED)) |-> (fired_tag == 16'd0))

endmodule

### rtl/tes_cell.sv
// One slot of the sorted deadline queue: holds an event and trades it with
// its neighbors on insert or pop. Depends on tes_pkg.
module tes_cell import tes_pkg::*; #(
  parameter int TIME_BITS   = 48,
  parameter int QUEUE_DEPTH = 64,
  parameter int INDEX       = 0
) (
  input  logic                               clk,
  input  cell_cmd_t                          cmd,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
  input  logic [TIME_BITS-1:0]               key_deadline,
  input  logic [31:0]                        key_period,
  input  logic [15:0]                        key_label,
  input  logic                               key_repeats,
  input  logic                               prev_gt,
  input  logic [TIME_BITS-1:0]               prev_deadline,
  input  logic [31:0]                        prev_period,
  input  logic [15:0]                        prev_label,
  input  logic                               prev_repeats,
  input  logic [TIME_BITS-1:0]               next_deadline,
  input  logic [31:0]                        next_period,
  input  logic [15:0]                        next_label,
  input  logic                               next_repeats,
  output logic                               gt,
  output logic [TIME_BITS-1:0]               deadline,
  output logic [31:0]                        period,
  output logic [15:0]                        label,
  output logic                               repeats
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] INDEX_W = CW'(INDEX);

  logic occupied;

  // Empty slots count as later than any key, so ties go behind.
  assign occupied = count > INDEX_W;
  assign gt       = !occupied || (deadline > key_deadline);

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      deadline <= next_deadline;
      period   <= next_period;
      label    <= next_label;
      repeats  <= next_repeats;
    end else if (cmd.insert && gt) begin
      if (prev_gt) begin
        deadline <= prev_deadline;
        period   <= prev_period;
        label    <= prev_label;
        repeats  <= prev_repeats;
      end else begin
        deadline <= key_deadline;
        period   <= key_period;
        label    <= key_label;
        repeats  <= key_repeats;
      end
    end
  end

endmodule

### tb/tb_timer_event_scheduler.sv
// Self-checking testbench for timer_event_scheduler: directed and random items are
// compared against an in-bench model of the earliest-deadline queue.
// Depends on tes_pkg and the timer_event_scheduler RTL.
`timescale 1ns / 100ps

module tb_timer_event_scheduler import tes_pkg::*;;

  localparam int DEPTH        = 64;
  localparam int TBITS        = 48;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam logic [TBITS-1:0] TIME_CEIL = '1;

  typedef struct {
    logic        op;
    logic [15:0] tag;
    logic        rep;
    logic [31:0] intv;
    int          gap;
    bit          drain;
  } sched_item_t;

  typedef struct {
    result_kind_t kind;
    logic [15:0]  tag;
    logic [6:0]   count;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_TICK;
  logic [15:0] event_tag = '0;
  logic        repeating = 1'b0;
  logic [31:0] interval = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [15:0] fired_tag;
  logic [6:0]  pending_count;

  timer_event_scheduler #(
    .QUEUE_DEPTH(DEPTH),
    .TIME_BITS  (TBITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .event_tag    (event_tag),
    .repeating    (repeating),
    .interval     (interval),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .fired_tag    (fired_tag),
    .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: sorted slots, earliest deadline at index 0.
  logic [TBITS-1:0] now_ticks = '0;
  logic [TBITS-1:0] slot_due[DEPTH];
  logic [31:0]      slot_period[DEPTH];
  logic [15:0]      slot_tag[DEPTH];
  logic             slot_rep[DEPTH];
  int               slots_used = 0;

  sched_item_t   pending_items[$];
  sched_result_t awaited_results[$];
  sched_item_t   cur_item;
  int            total_items;
  int            items_in = 0;
  int            results_out = 0;
  int            errors = 0;
  int            kind_total[4] = '{0, 0, 0, 0};
  int            peak_used = 0;

  function automatic logic [TBITS-1:0] sat_sum(logic [TBITS-1:0] base, logic [31:0] delta);
    logic [TBITS:0] sum;
    sum = {1'b0, base} + (TBITS + 1)'(delta);
    if (sum > {1'b0, TIME_CEIL}) return TIME_CEIL;
    return sum[TBITS-1:0];
  endfunction

  // Insert behind every slot with the same or an earlier deadline.
  function automatic void slot_insert(logic [TBITS-1:0] due, logic [31:0] period,
                                      logic [15:0] tag, logic rep);
    int pos;
    pos = slots_used;
    while (pos > 0 && slot_due[pos-1] > due) begin
      slot_due[pos]    = slot_due[pos-1];
      slot_period[pos] = slot_period[pos-1];
      slot_tag[pos]    = slot_tag[pos-1];
      slot_rep[pos]    = slot_rep[pos-1];
      pos--;
    end
    slot_due[pos]    = due;
    slot_period[pos] = period;
    slot_tag[pos]    = tag;
    slot_rep[pos]    = rep;
    slots_used++;
  endfunction

  function automatic sched_result_t timer_step_result(sched_item_t it);
    sched_result_t r;
    logic [31:0]   per;
    logic [15:0]   lab;
    logic          again;
    r.kind = KIND_IDLE;
    r.tag  = '0;
    if (it.op == OP_ADD) begin
      if (slots_used >= DEPTH) begin
        r.kind = KIND_FULL;
      end else begin
        slot_insert(sat_sum(now_ticks, it.intv), it.intv, it.tag, it.rep);
        r.kind = KIND_ADDED;
      end
    end else begin
      now_ticks = sat_sum(now_ticks, 32'd1);
      if (slots_used > 0 && slot_due[0] <= now_ticks) begin
        per   = slot_period[0];
        lab   = slot_tag[0];
        again = slot_rep[0];
        for (int i = 1; i < slots_used; i++) begin
          slot_due[i-1]    = slot_due[i];
          slot_period[i-1] = slot_period[i];
          slot_tag[i-1]    = slot_tag[i];
          slot_rep[i-1]    = slot_rep[i];
        end
        slots_used--;
        if (again) slot_insert(sat_sum(now_ticks, per), per, lab, again);
        r.tag  = lab;
        r.kind = KIND_FIRED;
      end
    end
    r.count = slots_used[6:0];
    return r;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(logic op, logic [15:0] tag, logic rep, logic [31:0] intv,
                           int gap, bit drain);
    sched_item_t it;
    it.op    = op;
    it.tag   = tag;
    it.rep   = rep;
    it.intv  = intv;
    it.gap   = gap;
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  task automatic push_random_add(int gap, bit drain);
    logic [31:0] intv;
    logic        rep;
    int          r;
    rep = ($urandom_range(0, 99) < 3);
    r   = $urandom_range(0, 99);
    if (rep)         intv = $urandom_range(5, 200);
    else if (r < 2)  intv = $urandom;
    else if (r < 10) intv = $urandom_range(41, 1000);
    else             intv = $urandom_range(0, 40);
    push_item(OP_ADD, 16'($urandom_range(0, 65535)), rep, intv, gap, drain);
  endtask

  // Driver: predict on accept; offer each item after its gap, drain items when idle.
  always @(posedge clk) begin
    bit            took;
    sched_result_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        r = timer_step_result(cur_item);
        awaited_results.push_back(r);
        kind_total[r.kind]++;
        if (int'(r.count) > peak_used) peak_used = int'(r.count);
        items_in <= items_in + 1;
      end
      if (!in_valid || took) begin
        if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_items[0].gap > 0) begin
          pending_items[0].gap--;
          in_valid <= 1'b0;
        end else if (pending_items[0].drain && (took || items_in != results_out)) begin
          in_valid <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          operation <= cur_item.op;
          event_tag <= cur_item.tag;
          repeating <= cur_item.rep;
          interval  <= cur_item.intv;
          in_valid  <= 1'b1;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off once traffic is under way.
  int  stall_left = 0;
  int  free_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_out >= 400) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (free_left > 0) begin
      free_left <= free_left - 1;
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= idle_len();
      free_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
    end
  end

  // Monitor: compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_out <= results_out + 1;
      if (awaited_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result %0d: kind %0d tag %h count %0d",
                   results_out, result_kind, fired_tag, pending_count);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (result_kind !== want.kind || fired_tag !== want.tag ||
            pending_count !== want.count) begin
          if (errors < 10)
            $display({"mismatch at result %0d: expected kind %0d tag %h count %0d, ",
                      "got kind %0d tag %h count %0d"},
                     results_out, want.kind, want.tag, want.count,
                     result_kind, fired_tag, pending_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: abort when neither side has moved an item for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int  target;
    int  b;
    int  len;
    bit  quiet;
    bit  drain;

    // Directed: empty tick, zero intervals, equal deadlines, repeats, far deadlines.
    push_item(OP_TICK, 16'h0000, 1'b0, 32'd0, 0, 1'b0);
    push_item(OP_ADD,  16'h0000, 1'b0, 32'd0, 0, 1'b0);
    push_item(OP_ADD,  16'hFFFF, 1'b0, 32'd0, 1, 1'b0);
    push_item(OP_TICK, 16'h0000, 1'b0, 32'd0, 0, 1'b0);
    push_item(OP_TICK, 16'h0000, 1'b0, 32'd0, 2, 1'b0);
    push_item(OP_ADD,  16'h1234, 1'b1, 32'd0, 0, 1'b0);
    push_item(OP_TICK, 16'h0000, 1'b0, 32'd0, 0, 1'b0);
    push_item(OP_TICK, 16'h0000, 1'b0, 32'd0, 0, 1'b0);
    push_item(OP_ADD,  16'h0002, 1'b0, 32'd3, 0, 1'b1);
    push_item(OP_ADD,  16'h0003, 1'b0, 32'd3, 0, 1'b0);
    push_item(OP_ADD,  16'h0004, 1'b1, 32'd2, 3, 1'b0);
    for (int i = 0; i < 7; i++) push_item(OP_TICK, 16'h0000, 1'b0, 32'd0, i % 2, 1'b0);
    push_item(OP_ADD,  16'h5A5A, 1'b0, 32'hFFFF_FFFF, 0, 1'b0);
    push_item(OP_ADD,  16'hA5A5, 1'b1, 32'h8000_0000, 0, 1'b0);
    push_item(OP_ADD,  16'h5555, 1'b0, 32'h5555_5555, 0, 1'b0);
    push_item(OP_ADD,  16'hAAAA, 1'b0, 32'hAAAA_AAAA, 0, 1'b0);
    push_item(OP_TICK, 16'h0000, 1'b0, 32'd0, 0, 1'b0);

    // Random: open with a fill burst so the full queue is reached early.
    target = pending_items.size() + RANDOM_ITEMS;
    b = 0;
    while (pending_items.size() < target) begin
      drain = (pending_items.size() + RANDOM_ITEMS == target) || ($urandom_range(0, 19) == 0);
      if (b < 10) begin
        for (int i = 0; i < 70; i++)
          push_item(OP_ADD, 16'($urandom_range(0, 65535)), 1'b0, $urandom_range(0, 60),
                    (i % 8 == 0) ? idle_len() : 0, drain && i == 0);
      end else if (b < 20) begin
        len = $urandom_range(30, 80);
        for (int i = 0; i < len; i++)
          push_item(OP_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    $urandom, idle_len(), drain && i == 0);
      end else begin
        len   = $urandom_range(20, 60);
        quiet = (b < 30);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 45)
            push_random_add(quiet ? 0 : idle_len(), drain && i == 0);
          else
            push_item(OP_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      $urandom, quiet ? 0 : idle_len(), drain && i == 0);
        end
      end
      b = $urandom_range(0, 99);
    end
    total_items = pending_items.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (items_in != total_items || results_out != items_in);
    repeat (8) @(posedge clk);
    errors += awaited_results.size();

    $display("Ran %0d items: %0d added, %0d rejected on a full queue, %0d fired,",
             total_items, kind_total[KIND_ADDED], kind_total[KIND_FULL],
             kind_total[KIND_FIRED]);
    $display("%0d empty ticks; peak occupancy %0d of %0d, final time %0d, %0d mismatches",
             kind_total[KIND_IDLE], peak_used, DEPTH, now_ticks, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
